@@ sv/tvi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tvi_pkg
// Types and fixed constants shared by the trilinear volume interpolator.
// ----------------------------------------------------------------------------
package tvi_pkg;

	localparam int MAX_ROWS    = 32;
	localparam int MAX_COLS    = 32;
	localparam int MAX_PAGES   = 32;
	localparam int MAX_VOLUMES = 2;
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int NEIGHBOURS  = 8;

	localparam int ROW_BITS  = $clog2(MAX_ROWS);
	localparam int COL_BITS  = $clog2(MAX_COLS);
	localparam int PAGE_BITS = $clog2(MAX_PAGES);
	localparam int VOL_BITS  = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;
	localparam int ADDR_BITS = VOL_BITS + PAGE_BITS + COL_BITS + ROW_BITS;
	localparam int STORE_DEPTH = MAX_VOLUMES * MAX_PAGES * MAX_COLS * MAX_ROWS;
	localparam int NB_BITS   = $clog2(NEIGHBOURS);

	// fraction weights run 0..2^FRAC_BITS, so one extra bit
	localparam int FW_BITS   = FRAC_BITS + 1;
	localparam int WXY_BITS  = 2 * FW_BITS;
	localparam int W_BITS    = 3 * FRAC_BITS + 1;
	localparam int SH_BITS   = 3 * FRAC_BITS;
	localparam int PROD_BITS = SAMPLE_BITS + W_BITS + 1;
	localparam int ACC_BITS  = PROD_BITS + 3;

	// register map, word index
	localparam logic [2:0] REG_NUM_ROWS   = 3'd0;
	localparam logic [2:0] REG_NUM_COLS   = 3'd1;
	localparam logic [2:0] REG_NUM_PAGES  = 3'd2;
	localparam logic [2:0] REG_NUM_VOLS   = 3'd3;
	localparam logic [2:0] REG_BACKGROUND = 3'd4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [15:0]        write_address;
		logic signed [15:0] write_value;
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
		logic signed [15:0] z_coord;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] interp_value;
		logic               volume_index;
		logic               outside;
		logic               last;
	} out_item_t;

endpackage : tvi_pkg
`default_nettype wire

@@ sv/trilinear_volume_interpolator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trilinear_volume_interpolator_core
// Trilinear interpolation over a stack of sample volumes held in one RAM.
// ----------------------------------------------------------------------------
// A write beat stores one sample. A query beat returns one result beat per
// volume in use, volume 0 first, last set on the final one. Each inside
// volume reads its 8 neighbours from the single-port sample RAM (one read
// per cycle), then drains the weight/multiply/accumulate pipeline and loads
// the output register. An outside query skips the reads and loads one
// background result per volume. The sequencer stalls while a result is to
// be loaded and the output register is full and not taken.
// The input side is ready whenever the sequencer is idle; the output register
// decouples it, so the next beat is taken while a result waits. Sample memory
// contents are undefined until written; there is no clearing pass.
// Weights are exact products of the Q8.8 fractions (24 fraction bits), and
// the sum is rounded to nearest with ties toward +infinity.
// ----------------------------------------------------------------------------
module trilinear_volume_interpolator_core
	import tvi_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	// item input
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	// result output
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_PUSH  = 4'b1000
	} state_t;

	// ---------------- registers ----------------
	logic [5:0]         num_rows_q, num_cols_q, num_pages_q;
	logic [1:0]         num_vols_q;
	logic signed [15:0] background_q;
	logic               cfg_wr;
	logic [2:0]         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];

	// clamp helper
	function automatic logic [5:0] clamp_ext(input logic [5:0] v, input logic [5:0] hi);
		logic [5:0] r;
		r = v;
		if (v < 6'd2) begin
			r = 6'd2;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q   <= 6'(MAX_ROWS);
			num_cols_q   <= 6'(MAX_COLS);
			num_pages_q  <= 6'(MAX_PAGES);
			num_vols_q   <= 2'd1;
			background_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_NUM_ROWS:   num_rows_q  <= clamp_ext(pwdata[5:0], 6'(MAX_ROWS));
				REG_NUM_COLS:   num_cols_q  <= clamp_ext(pwdata[5:0], 6'(MAX_COLS));
				REG_NUM_PAGES:  num_pages_q <= clamp_ext(pwdata[5:0], 6'(MAX_PAGES));
				REG_NUM_VOLS: begin
					if (pwdata[1:0] == 2'd0) begin
						num_vols_q <= 2'd1;
					end else if (pwdata[1:0] > 2'(MAX_VOLUMES)) begin
						num_vols_q <= 2'(MAX_VOLUMES);
					end else begin
						num_vols_q <= pwdata[1:0];
					end
				end
				REG_BACKGROUND: background_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_NUM_ROWS:   prdata = {26'd0, num_rows_q};
			REG_NUM_COLS:   prdata = {26'd0, num_cols_q};
			REG_NUM_PAGES:  prdata = {26'd0, num_pages_q};
			REG_NUM_VOLS:   prdata = {30'd0, num_vols_q};
			REG_BACKGROUND: prdata = {{16{background_q[15]}}, background_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------- query decode ----------------
	localparam logic [FW_BITS-1:0] ONE_FW = FW_BITS'(1) << FRAC_BITS;

	logic signed [16:0] lim_x, lim_y, lim_z, one_c;
	logic               q_outside;
	logic               in_acc;

	assign one_c = 17'sd1 <<< FRAC_BITS;
	assign lim_x = signed'({11'd0, num_cols_q}) <<< FRAC_BITS;
	assign lim_y = signed'({11'd0, num_rows_q}) <<< FRAC_BITS;
	assign lim_z = signed'({11'd0, num_pages_q}) <<< FRAC_BITS;
	assign q_outside =
		(17'(in_data.x_coord) < one_c) || (17'(in_data.x_coord) > lim_x) ||
		(17'(in_data.y_coord) < one_c) || (17'(in_data.y_coord) > lim_y) ||
		(17'(in_data.z_coord) < one_c) || (17'(in_data.z_coord) > lim_z);

	// neighbour indexes and fractions of the current query
	logic [COL_BITS-1:0]  c0_q, c1_q;
	logic [ROW_BITS-1:0]  r0_q, r1_q;
	logic [PAGE_BITS-1:0] p0_q, p1_q;
	logic [FW_BITS-1:0]   fxl_q, fxh_q, fyl_q, fyh_q, fzl_q, fzh_q;
	logic                 outside_q;

	logic [COL_BITS-1:0]  c0_d;
	logic [ROW_BITS-1:0]  r0_d;
	logic [PAGE_BITS-1:0] p0_d;
	logic [FW_BITS-1:0]   xl_d, yl_d, zl_d;

	assign c0_d = COL_BITS'(in_data.x_coord[15:FRAC_BITS] - 1'b1);
	assign r0_d = ROW_BITS'(in_data.y_coord[15:FRAC_BITS] - 1'b1);
	assign p0_d = PAGE_BITS'(in_data.z_coord[15:FRAC_BITS] - 1'b1);
	assign xl_d = {1'b0, in_data.x_coord[FRAC_BITS-1:0]};
	assign yl_d = {1'b0, in_data.y_coord[FRAC_BITS-1:0]};
	assign zl_d = {1'b0, in_data.z_coord[FRAC_BITS-1:0]};

	always_ff @(posedge clk) begin
		if (in_acc && in_data.opcode == OP_QUERY) begin
			outside_q <= q_outside;
			c0_q  <= c0_d;
			r0_q  <= r0_d;
			p0_q  <= p0_d;
			// upper edge: no step to the next neighbour
			c1_q  <= (17'(in_data.x_coord) == lim_x) ? c0_d : c0_d + 1'b1;
			r1_q  <= (17'(in_data.y_coord) == lim_y) ? r0_d : r0_d + 1'b1;
			p1_q  <= (17'(in_data.z_coord) == lim_z) ? p0_d : p0_d + 1'b1;
			fxl_q <= xl_d;
			fyl_q <= yl_d;
			fzl_q <= zl_d;
			fxh_q <= ONE_FW - xl_d;
			fyh_q <= ONE_FW - yl_d;
			fzh_q <= ONE_FW - zl_d;
		end
	end

	// ---------------- sequencer ----------------
	state_t              state_q;
	logic [NB_BITS-1:0]  nb_q;
	logic [VOL_BITS-1:0] vol_q;
	logic                done_q;
	logic                out_valid_q;
	out_item_t           out_q;
	logic                push_ok;
	logic                vol_last;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign push_ok  = !out_valid_q || out_ready;
	assign vol_last = (2'(vol_q) + 2'd1 == num_vols_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nb_q    <= '0;
			vol_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					nb_q  <= '0;
					vol_q <= '0;
					if (in_acc && in_data.opcode == OP_QUERY) begin
						state_q <= q_outside ? ST_PUSH : ST_READ;
					end
				end
				ST_READ: begin
					nb_q <= nb_q + 1'b1;
					if (nb_q == NB_BITS'(NEIGHBOURS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (done_q) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ok) begin
						if (vol_last) begin
							state_q <= ST_IDLE;
						end else begin
							vol_q   <= vol_q + 1'b1;
							nb_q    <= '0;
							state_q <= outside_q ? ST_PUSH : ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- sample RAM ----------------
	logic                   ram_we;
	logic [ADDR_BITS-1:0]   ram_addr;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic                   iy, ix, iz;

	assign iy = nb_q[0];
	assign ix = nb_q[1];
	assign iz = nb_q[2];
	assign ram_we = in_acc && in_data.opcode == OP_WRITE;

	always_comb begin
		if (state_q == ST_READ) begin
			ram_addr = {vol_q, iz ? p1_q : p0_q, ix ? c1_q : c0_q, iy ? r1_q : r0_q};
		end else begin
			ram_addr = in_data.write_address[ADDR_BITS-1:0];
		end
	end

	tvi_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_data.write_value[SAMPLE_BITS-1:0]),
		.rdata (ram_rdata)
	);

	// ---------------- weight / MAC pipeline ----------------
	// s1: RAM data out, partial weight fy*fx
	// s2: sample and full weight
	// s3: sample * weight
	logic                    vld_s1, vld_s2, vld_s3;
	logic                    first_s1, first_s2, first_s3;
	logic                    lastnb_s1, lastnb_s2, lastnb_s3;
	logic [WXY_BITS-1:0]     wxy_s1;
	logic [FW_BITS-1:0]      fz_s1;
	logic [SAMPLE_BITS-1:0]  sample_s2;
	logic [W_BITS-1:0]       w_s2;
	logic signed [PROD_BITS-1:0] prod_s3;
	logic signed [ACC_BITS-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_READ);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (state_q == ST_READ) begin
				done_q <= 1'b0;
			end else if (vld_s3 && lastnb_s3) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1  <= (nb_q == '0);
		lastnb_s1 <= (nb_q == NB_BITS'(NEIGHBOURS - 1));
		wxy_s1    <= (iy ? fyl_q : fyh_q) * (ix ? fxl_q : fxh_q);
		fz_s1     <= iz ? fzl_q : fzh_q;

		first_s2  <= first_s1;
		lastnb_s2 <= lastnb_s1;
		sample_s2 <= ram_rdata;
		w_s2      <= W_BITS'(wxy_s1) * W_BITS'(fz_s1);

		first_s3  <= first_s2;
		lastnb_s3 <= lastnb_s2;
		prod_s3   <= signed'(sample_s2) * signed'({1'b0, w_s2});

		if (vld_s3) begin
			acc_q <= (first_s3 ? ACC_BITS'(0) : acc_q) + ACC_BITS'(prod_s3);
		end
	end

	// ---------------- rounding and output ----------------
	localparam int RND_BITS = ACC_BITS - SH_BITS;

	logic signed [ACC_BITS-1:0] acc_rnd;
	logic signed [RND_BITS-1:0] rnd;
	logic signed [15:0]         rnd_sat;

	assign acc_rnd = acc_q + (ACC_BITS'(1) <<< (SH_BITS - 1));
	assign rnd     = acc_rnd[ACC_BITS-1:SH_BITS];

	always_comb begin
		if (rnd > RND_BITS'(32767)) begin
			rnd_sat = 16'sh7fff;
		end else if (rnd < -RND_BITS'(32768)) begin
			rnd_sat = -16'sh8000;
		end else begin
			rnd_sat = rnd[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && push_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && push_ok) begin
			out_q.interp_value <= outside_q ? background_q : rnd_sat;
			out_q.volume_index <= vol_q[0];
			out_q.outside      <= outside_q;
			out_q.last         <= vol_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule : trilinear_volume_interpolator_core
`default_nettype wire

@@ sv/tvi_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tvi_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tvi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule : tvi_ram
`default_nettype wire

@@ sv/tvi_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tvi_checker
// Port-level checks for the trilinear volume interpolator, bound to the core.
// ----------------------------------------------------------------------------
module tvi_checker
	import tvi_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire in_item_t    in_data,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire out_item_t   out_data,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [4:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// a query keeps the input side busy for at least the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.opcode == OP_QUERY |=> !in_ready)
		else $error("input ready right after a query beat");

	// a non-final result can only be the first volume
	a_first_vol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.volume_index == 1'b0)
		else $error("non-final result not from volume 0");

	// register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule : tvi_checker

bind trilinear_volume_interpolator_core tvi_checker u_tvi_checker (.*);
`default_nettype wire

@@ test/trilinear_volume_interpolator_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trilinear_volume_interpolator_core_tb
// Self-checking bench for the trilinear volume interpolator.
// ----------------------------------------------------------------------------
// Sample beats fill the store and are mirrored in a local copy. Query beats
// are predicted from that copy and the current register values. Queries only
// ever touch samples that have already been written: every test first fills
// the region it will read. Results are checked in order against a queue of
// expected beats. Register writes go through the APB port only while idle.
// ----------------------------------------------------------------------------
module trilinear_volume_interpolator_core_tb;
	import tvi_pkg::*;

	localparam int DRAIN_CYCLES = 64;
	localparam int STALL_LIMIT  = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// local mirror of the block state
	logic signed [15:0] sample_mirror [STORE_DEPTH];
	bit                 sample_written [STORE_DEPTH];
	int unsigned        rows_cfg, cols_cfg, pages_cfg, vols_cfg;
	logic signed [15:0] background_cfg;

	out_item_t   expected_results [$];
	int          error_count = 0;
	int          idle_count = 0;
	bit          no_idle = 1'b0;

	always #5 clk = ~clk;

	trilinear_volume_interpolator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// watchdog: cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count > STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random stall, compare each beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result beat %p", out_data);
					error_count++;
				end else begin
					out_item_t e;
					e = expected_results.pop_front();
					if (out_data.interp_value !== e.interp_value) begin
						$error("interp_value exp %0d got %0d", e.interp_value,
							out_data.interp_value);
						error_count++;
					end
					if (out_data.volume_index !== e.volume_index) begin
						$error("volume_index exp %0d got %0d", e.volume_index,
							out_data.volume_index);
						error_count++;
					end
					if (out_data.outside !== e.outside) begin
						$error("outside exp %0d got %0d", e.outside, out_data.outside);
						error_count++;
					end
					if (out_data.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, out_data.last);
						error_count++;
					end
				end
			end
			out_ready <= no_idle || ($urandom_range(99) >= 14);
		end
	end

	function automatic int unsigned sample_addr(int unsigned v, int unsigned p,
			int unsigned c, int unsigned r);
		return ((v * MAX_PAGES + p) * MAX_COLS + c) * MAX_ROWS + r;
	endfunction

	// trilinear prediction of one query beat
	task automatic predict_query(in_item_t it);
		longint x, y, z, acc, res;
		int unsigned c0, r0, p0, cc[2], rr[2], pp[2];
		longint fx[2], fy[2], fz[2];
		bit is_out;
		out_item_t o;
		x = it.x_coord; y = it.y_coord; z = it.z_coord;
		is_out = x < 256 || x > (cols_cfg << 8) || y < 256 || y > (rows_cfg << 8)
			|| z < 256 || z > (pages_cfg << 8);
		if (!is_out) begin
			c0 = (x >> 8) - 1; r0 = (y >> 8) - 1; p0 = (z >> 8) - 1;
			cc[0] = c0; cc[1] = c0 + ((x == (cols_cfg << 8)) ? 0 : 1);
			rr[0] = r0; rr[1] = r0 + ((y == (rows_cfg << 8)) ? 0 : 1);
			pp[0] = p0; pp[1] = p0 + ((z == (pages_cfg << 8)) ? 0 : 1);
			fx[1] = x & 255; fx[0] = 256 - fx[1];
			fy[1] = y & 255; fy[0] = 256 - fy[1];
			fz[1] = z & 255; fz[0] = 256 - fz[1];
		end
		for (int v = 0; v < vols_cfg; v++) begin
			if (is_out) begin
				o.interp_value = background_cfg;
			end else begin
				acc = 0;
				for (int k = 0; k < NEIGHBOURS; k++) begin
					int unsigned a;
					a = sample_addr(v, pp[k >> 2], cc[(k >> 1) & 1], rr[k & 1]);
					if (!sample_written[a])
						$error("bench bug: query reads unwritten sample %0d", a);
					acc += longint'(sample_mirror[a]) * fy[k & 1] * fx[(k >> 1) & 1]
						* fz[k >> 2];
				end
				// floor shift after half-LSB add: ties go toward +infinity
				res = (acc + (longint'(1) << 23)) >>> 24;
				if (res > 32767) res = 32767;
				if (res < -32768) res = -32768;
				o.interp_value = res[15:0];
			end
			o.volume_index = v[0];
			o.outside = is_out;
			o.last = (v + 1 == vols_cfg);
			expected_results.push_back(o);
		end
	endtask

	// send one beat; valid stays high across back-to-back beats
	task automatic send_beat(in_item_t it);
		while (!no_idle && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (it.opcode == OP_WRITE) begin
			sample_mirror[it.write_address] = it.write_value;
			sample_written[it.write_address] = 1'b1;
		end else begin
			predict_query(it);
		end
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_sample(int unsigned a, logic signed [15:0] val);
		in_item_t it;
		it = '0;
		it.opcode = OP_WRITE;
		it.write_address = a[15:0];
		it.write_value = val;
		it.x_coord = $urandom; it.y_coord = $urandom; it.z_coord = $urandom;
		send_beat(it);
	endtask

	task automatic send_query(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		in_item_t it;
		it.opcode = OP_QUERY;
		it.write_address = $urandom;
		it.write_value = $urandom;
		it.x_coord = x; it.y_coord = y; it.z_coord = z;
		send_beat(it);
	endtask

	// wait for all results, then the block's own latency
	task automatic wait_drained();
		release_input();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_NUM_ROWS:   rows_cfg  = (val[5:0] < 2) ? 2 : (val[5:0] > 32) ? 32 : val[5:0];
			REG_NUM_COLS:   cols_cfg  = (val[5:0] < 2) ? 2 : (val[5:0] > 32) ? 32 : val[5:0];
			REG_NUM_PAGES:  pages_cfg = (val[5:0] < 2) ? 2 : (val[5:0] > 32) ? 32 : val[5:0];
			REG_NUM_VOLS:   vols_cfg  = (val[1:0] < 1) ? 1 : (val[1:0] > 2) ? 2 : val[1:0];
			REG_BACKGROUND: background_cfg = val[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(int unsigned r, int unsigned c, int unsigned p,
			int unsigned nv, logic signed [15:0] bg);
		apb_write(REG_NUM_ROWS, r);
		apb_write(REG_NUM_COLS, c);
		apb_write(REG_NUM_PAGES, p);
		apb_write(REG_NUM_VOLS, nv);
		apb_write(REG_BACKGROUND, {16'hffff, bg});
	endtask

	// fill the region rows x cols x pages of both volumes
	task automatic fill_region(int unsigned r, int unsigned c, int unsigned p,
			bit extreme);
		for (int v = 0; v < MAX_VOLUMES; v++)
			for (int pg = 0; pg < p; pg++)
				for (int cl = 0; cl < c; cl++)
					for (int rw = 0; rw < r; rw++)
						write_sample(sample_addr(v, pg, cl, rw),
							extreme ? (($urandom_range(1)) ? 16'sh7fff : 16'sh8000)
								: 16'($urandom));
	endtask

	function automatic logic signed [15:0] rand_coord(int unsigned n);
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 80) return 16'($urandom_range(256, n << 8));
		if (sel < 90) return 16'(($urandom_range(1, n)) << 8);
		return 16'($urandom);
	endfunction

	// directed: edges, exact grid points, corners, outside cases, extreme sample values
	task automatic test_directed();
		configure(2, 2, 2, 2, 16'sh8000);
		fill_region(2, 2, 2, 1'b1);
		send_query(16'sh0100, 16'sh0100, 16'sh0100);
		send_query(16'sh0200, 16'sh0200, 16'sh0200);
		send_query(16'sh0180, 16'sh0180, 16'sh0180);
		send_query(16'sh01ff, 16'sh0101, 16'sh01ff);
		send_query(16'sh0200, 16'sh0180, 16'sh0101);
		send_query(16'sh00ff, 16'sh0180, 16'sh0180);
		send_query(16'sh0180, 16'sh0201, 16'sh0180);
		send_query(16'sh0180, 16'sh0180, 16'sh8000);
		send_query(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_query(16'shffff, 16'sh0000, 16'sh0100);
		wait_drained();
		configure(32, 32, 32, 1, 16'sh7fff);
		for (int k = 0; k < 8; k++)
			write_sample(sample_addr(0, 30 + (k >> 2), 30 + ((k >> 1) & 1), 30 + (k & 1)),
				16'sh7fff);
		write_sample(16'hffff, 16'sh1234);
		send_query(16'sh1f80, 16'sh1f80, 16'sh1f80);
		send_query(16'sh2000, 16'sh2000, 16'sh2000);
		send_query(16'sh2001, 16'sh1f00, 16'sh1f00);
		send_query(16'sh1f00, 16'sh1f00, 16'sh0000);
		wait_drained();
	endtask

	// random phases over several extents; most traffic is in-range queries
	task automatic test_random(int unsigned beats);
		int unsigned r, c, p;
		for (int ph = 0; ph < 6; ph++) begin
			no_idle = (ph == 2);
			r = (ph == 0) ? 2 : $urandom_range(2, 6);
			c = $urandom_range(2, 6);
			p = (ph == 5) ? 3 : $urandom_range(2, 6);
			configure(r, c, p, $urandom_range(0, 3), 16'($urandom));
			fill_region(r, c, p, 1'b0);
			for (int i = 0; i < beats / 6; i++) begin
				if ($urandom_range(99) < 15)
					write_sample(sample_addr($urandom_range(1), $urandom_range(p - 1),
						$urandom_range(c - 1), $urandom_range(r - 1)), 16'($urandom));
				else
					send_query(rand_coord(c), rand_coord(r), rand_coord(p));
			end
			wait_drained();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		rows_cfg = 32; cols_cfg = 32; pages_cfg = 32; vols_cfg = 1;
		background_cfg = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(800);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
